@@ sv/iba_pkg.sv @@
// package for the image identifier bitmap allocator
// sizes, codes, sequencer states, memory port struct and reset word function
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package iba_pkg;

  // word_bits must be a power of two
  localparam int unsigned ID_COUNT  = 65536;
  localparam int unsigned WORD_BITS = 32;

  localparam int unsigned MAP_WORDS = (ID_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned BIT_W     = $clog2(WORD_BITS);
  localparam int unsigned LAST_BITS = ID_COUNT - (MAP_WORDS - 1) * WORD_BITS;

  localparam int unsigned FIELD_W   = 16;
  localparam logic [FIELD_W-1:0] SIZE_LIMIT = 16'h1000;

  localparam logic [ADDR_W-1:0]    LAST_ADDR = ADDR_W'(MAP_WORDS - 1);
  localparam logic [WORD_BITS-1:0] FULL_MASK = {WORD_BITS{1'b1}};
  localparam logic [WORD_BITS-1:0] LAST_MASK = FULL_MASK >> (WORD_BITS - LAST_BITS);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [BIT_W-1:0]     bit_idx_t;

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_DONE,
    ST_REL_RD,
    ST_REL_WR
  } state_e;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    word_t wdata;
    logic  re;
    addr_t raddr;
  } ram_req_t;

  function automatic word_t init_word(addr_t addr);
    word_t w;
    w = (addr == LAST_ADDR) ? LAST_MASK : FULL_MASK;
    if (addr == '0) begin
      w[0] = 1'b0;
    end
    return w;
  endfunction

endpackage

`default_nettype wire

@@ sv/iba_map_ram.sv @@
// free bitmap storage, one write and one registered read port
// depends on iba_pkg
`timescale 1ns / 1ps
`default_nettype none

module iba_map_ram (
  input  wire logic             clk_i,
  input  wire iba_pkg::ram_req_t req_i,
  output iba_pkg::word_t         rdata_o
);

  iba_pkg::word_t mem [iba_pkg::MAP_WORDS];
  iba_pkg::word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ sv/iba_first_set.sv @@
// lowest set bit finder for one bitmap word
// gives the bit index and the word with that bit cleared; depends on iba_pkg
`timescale 1ns / 1ps
`default_nettype none

module iba_first_set (
  input  wire iba_pkg::word_t word_i,
  output logic                found_o,
  output iba_pkg::bit_idx_t   idx_o,
  output iba_pkg::word_t      cleared_o
);

  iba_pkg::word_t onehot;

  assign onehot    = word_i & (~word_i + iba_pkg::word_t'(1));
  assign cleared_o = word_i & ~onehot;
  assign found_o   = (word_i != '0);

  always_comb begin
    idx_o = '0;
    for (int i = 0; i < int'(iba_pkg::WORD_BITS); i++) begin
      if (onehot[i]) begin
        idx_o = idx_o | iba_pkg::bit_idx_t'(i);
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/image_id_bitmap_allocator.sv @@
// allocate: the scan reads words from address 0 up to the first non-empty word (or the last),
// then registers the result; a refused size goes straight to its result, with no scan
// release: word read, then written with the bit set (skipped for id zero or out of range); no result
// one item at a time, set by the one-word-a-cycle scan
// after reset a pass over all MAP_WORDS words (2048) writes the free map, with no item taken
// depends on iba_pkg, iba_map_ram, iba_first_set
`timescale 1ns / 1ps
`default_nettype none

module image_id_bitmap_allocator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        command_i,
  input  wire logic [15:0] img_width_i,
  input  wire logic [15:0] img_height_i,
  input  wire logic [15:0] release_id_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      granted_id_o,
  output logic             granted_o
);

  iba_pkg::state_e   state_q, state_d;
  iba_pkg::addr_t    rd_addr_q, rd_addr_d;
  logic              issue_q, issue_d;
  logic              chk_valid_q, chk_valid_d;
  iba_pkg::addr_t    chk_addr_q;
  iba_pkg::bit_idx_t rel_bit_q;
  logic              res_ok_q;
  iba_pkg::addr_t    res_addr_q;
  iba_pkg::word_t    res_word_q;
  logic [15:0]       res_id_q;
  logic              out_valid_q;
  logic [15:0]       granted_id_q;
  logic              granted_q;

  iba_pkg::ram_req_t ram_req;
  iba_pkg::word_t    rdata;
  logic              fs_found;
  iba_pkg::bit_idx_t fs_idx;
  iba_pkg::word_t    fs_cleared;

  logic        accept;
  logic        size_ok;
  logic        rel_ok;
  logic        out_free;
  logic [31:0] hit_id;

  iba_map_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (rdata)
  );

  iba_first_set u_first (
    .word_i    (rdata),
    .found_o   (fs_found),
    .idx_o     (fs_idx),
    .cleared_o (fs_cleared)
  );

  assign accept   = in_valid_i && in_ready_o;
  assign size_ok  = (img_width_i < iba_pkg::SIZE_LIMIT) && (img_height_i < iba_pkg::SIZE_LIMIT);
  assign rel_ok   = (release_id_i != '0) && ({1'b0, release_id_i} < 17'(iba_pkg::ID_COUNT));
  assign out_free = !out_valid_q || out_ready_i;
  assign hit_id   = (32'(chk_addr_q) << iba_pkg::BIT_W) | 32'(fs_idx);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      iba_pkg::ST_INIT: begin
        if (rd_addr_q == iba_pkg::LAST_ADDR) begin
          state_d = iba_pkg::ST_IDLE;
        end
      end
      iba_pkg::ST_IDLE: begin
        if (accept) begin
          priority if (command_i == iba_pkg::CMD_RELEASE) begin
            if (rel_ok) begin
              state_d = iba_pkg::ST_REL_RD;
            end
          end else if (size_ok) begin
            state_d = iba_pkg::ST_SCAN;
          end else begin
            state_d = iba_pkg::ST_DONE;
          end
        end
      end
      iba_pkg::ST_SCAN: begin
        if (chk_valid_q && (fs_found || chk_addr_q == iba_pkg::LAST_ADDR)) begin
          state_d = iba_pkg::ST_DONE;
        end
      end
      iba_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = iba_pkg::ST_IDLE;
        end
      end
      iba_pkg::ST_REL_RD: state_d = iba_pkg::ST_REL_WR;
      iba_pkg::ST_REL_WR: state_d = iba_pkg::ST_IDLE;
      default:            state_d = iba_pkg::ST_INIT;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    ram_req    = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      iba_pkg::ST_INIT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = rd_addr_q;
        ram_req.wdata = iba_pkg::init_word(rd_addr_q);
      end
      iba_pkg::ST_IDLE: in_ready_o = 1'b1;
      iba_pkg::ST_SCAN: begin
        ram_req.re    = issue_q;
        ram_req.raddr = rd_addr_q;
      end
      iba_pkg::ST_DONE: begin
        ram_req.we    = out_free && res_ok_q;
        ram_req.waddr = res_addr_q;
        ram_req.wdata = res_word_q;
      end
      iba_pkg::ST_REL_RD: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = rd_addr_q;
      end
      iba_pkg::ST_REL_WR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = rd_addr_q;
        ram_req.wdata = rdata | (iba_pkg::word_t'(1) << rel_bit_q);
      end
      default: ram_req = '0;
    endcase
  end

  // scan address and pipeline control
  always_comb begin
    rd_addr_d   = rd_addr_q;
    issue_d     = issue_q;
    chk_valid_d = 1'b0;
    unique case (state_q)
      iba_pkg::ST_INIT: begin
        rd_addr_d = rd_addr_q + iba_pkg::addr_t'(1);
      end
      iba_pkg::ST_IDLE: begin
        if (accept) begin
          issue_d = 1'b1;
          if (command_i == iba_pkg::CMD_RELEASE) begin
            rd_addr_d = iba_pkg::addr_t'(release_id_i >> iba_pkg::BIT_W);
          end else begin
            rd_addr_d = '0;
          end
        end
      end
      iba_pkg::ST_SCAN: begin
        if (issue_q) begin
          chk_valid_d = 1'b1;
          if (rd_addr_q == iba_pkg::LAST_ADDR) begin
            issue_d = 1'b0;
          end else begin
            rd_addr_d = rd_addr_q + iba_pkg::addr_t'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= iba_pkg::ST_INIT;
      rd_addr_q   <= '0;
      issue_q     <= 1'b0;
      chk_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_addr_q   <= rd_addr_d;
      issue_q     <= issue_d;
      chk_valid_q <= chk_valid_d;
      if (state_q == iba_pkg::ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chk_addr_q <= rd_addr_q;
    if (accept) begin
      rel_bit_q <= release_id_i[iba_pkg::BIT_W-1:0];
      res_ok_q  <= 1'b0;
      res_id_q  <= '0;
    end
    if (state_q == iba_pkg::ST_SCAN && chk_valid_q && fs_found) begin
      res_ok_q   <= 1'b1;
      res_id_q   <= hit_id[15:0];
      res_addr_q <= chk_addr_q;
      res_word_q <= fs_cleared;
    end
    if (state_q == iba_pkg::ST_DONE && out_free) begin
      granted_id_q <= res_id_q;
      granted_q    <= res_ok_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign granted_id_o = granted_id_q;
  assign granted_o    = granted_q;

endmodule

`default_nettype wire

@@ tb/tb_image_id_bitmap_allocator.sv @@
// testbench for image_id_bitmap_allocator: directed and random allocate and release items,
// with a scoreboard class that predicts each grant from its own copy of the free map
// depends on iba_pkg and the allocator rtl
`timescale 1ns / 1ps

typedef logic [iba_pkg::FIELD_W-1:0] id_t;

typedef struct packed {
  id_t  id;
  logic granted;
} grant_t;

class grant_scoreboard;
  iba_pkg::word_t free_words [iba_pkg::MAP_WORDS];
  grant_t         expected_grants [$];
  int unsigned    mismatches;
  int unsigned    grants_checked;
  int unsigned    refusals_checked;
  int unsigned    releases_noted;
  int unsigned    highest_id;

  function new();
    iba_pkg::word_t word;
    for (int wi = 0; wi < iba_pkg::MAP_WORDS; wi++) begin
      word = '1;
      if ((wi + 1) * iba_pkg::WORD_BITS > iba_pkg::ID_COUNT) begin
        word = word >> ((wi + 1) * iba_pkg::WORD_BITS - iba_pkg::ID_COUNT);
      end
      free_words[wi] = word;
    end
    // identifier zero is reserved
    free_words[0][0] = 1'b0;
    mismatches       = 0;
    grants_checked   = 0;
    refusals_checked = 0;
    releases_noted   = 0;
    highest_id       = 0;
  endfunction

  function grant_t note_request(iba_pkg::cmd_e cmd, id_t img_w, id_t img_h, id_t rel);
    grant_t g;
    bit     found;
    g     = '{id: '0, granted: 1'b0};
    found = 1'b0;
    if (cmd == iba_pkg::CMD_RELEASE) begin
      releases_noted++;
      if (rel != '0 && rel < iba_pkg::ID_COUNT) begin
        free_words[rel / iba_pkg::WORD_BITS][rel % iba_pkg::WORD_BITS] = 1'b1;
      end
      return g;
    end
    if (img_w < iba_pkg::SIZE_LIMIT && img_h < iba_pkg::SIZE_LIMIT) begin
      for (int wi = 0; wi < iba_pkg::MAP_WORDS; wi++) begin
        if (!found && free_words[wi] != '0) begin
          for (int bi = 0; bi < iba_pkg::WORD_BITS; bi++) begin
            if (!found && free_words[wi][bi]) begin
              found              = 1'b1;
              free_words[wi][bi] = 1'b0;
              g.id               = id_t'(wi * iba_pkg::WORD_BITS + bi);
              g.granted          = 1'b1;
            end
          end
        end
      end
    end
    expected_grants.push_back(g);
    return g;
  endfunction

  function void check_grant(id_t id, logic granted);
    grant_t g;
    if (expected_grants.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual granted_id %0d granted %0b",
               $time, id, granted);
      mismatches++;
      return;
    end
    g = expected_grants.pop_front();
    if (id !== g.id) begin
      $display("%0t: granted_id mismatch, expected %0d, actual %0d", $time, g.id, id);
      mismatches++;
    end
    if (granted !== g.granted) begin
      $display("%0t: granted mismatch, expected %0b, actual %0b", $time, g.granted, granted);
      mismatches++;
    end
    if (g.granted) begin
      grants_checked++;
      if (g.id > highest_id) begin
        highest_id = g.id;
      end
    end else begin
      refusals_checked++;
    end
  endfunction
endclass

module tb_image_id_bitmap_allocator;

  localparam int RESET_CYCLES   = 9;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int QUIET_LIMIT    = 20000;
  localparam int IDLE_PCT       = 18;

  localparam id_t SIZE_MAX = id_t'(iba_pkg::SIZE_LIMIT - 1);

  logic clk_i        = 1'b0;
  logic rst_ni       = 1'b0;
  logic in_valid_i   = 1'b0;
  logic in_ready_o;
  logic command_i    = 1'b0;
  id_t  img_width_i  = '0;
  id_t  img_height_i = '0;
  id_t  release_id_i = '0;
  logic out_valid_o;
  logic out_ready_i  = 1'b0;
  id_t  granted_id_o;
  logic granted_o;

  logic hold_off_req = 1'b0;
  int   idle_pct     = IDLE_PCT;
  int   items_sent   = 0;
  id_t  ids_in_use [$];

  grant_scoreboard sb = new();

  always #1 clk_i = ~clk_i;

  image_id_bitmap_allocator i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .img_width_i  (img_width_i),
    .img_height_i (img_height_i),
    .release_id_i (release_id_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .granted_id_o (granted_id_o),
    .granted_o    (granted_o)
  );

  task automatic send_request(iba_pkg::cmd_e cmd, id_t img_w, id_t img_h, id_t rel);
    grant_t g;
    int     idx [$];
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    img_width_i  <= img_w;
    img_height_i <= img_h;
    release_id_i <= rel;
    do @(posedge clk_i); while (!in_ready_o);
    g = sb.note_request(cmd, img_w, img_h, rel);
    items_sent++;
    if (cmd == iba_pkg::CMD_ALLOC && g.granted) begin
      ids_in_use.push_back(g.id);
    end else if (cmd == iba_pkg::CMD_RELEASE) begin
      idx = ids_in_use.find_first_index(x) with (x == rel);
      if (idx.size() != 0) begin
        ids_in_use.delete(idx[0]);
      end
    end
  endtask

  task automatic random_request();
    int  r;
    id_t pick;
    r = $urandom_range(99);
    if (r < 60) begin
      send_request(iba_pkg::CMD_ALLOC, id_t'($urandom_range(SIZE_MAX)),
                   id_t'($urandom_range(SIZE_MAX)), id_t'($urandom));
    end else if (r < 68) begin
      if ($urandom_range(1)) begin
        send_request(iba_pkg::CMD_ALLOC, id_t'($urandom_range(16'hffff, iba_pkg::SIZE_LIMIT)),
                     id_t'($urandom), id_t'($urandom));
      end else begin
        send_request(iba_pkg::CMD_ALLOC, id_t'($urandom),
                     id_t'($urandom_range(16'hffff, iba_pkg::SIZE_LIMIT)), id_t'($urandom));
      end
    end else if (r < 90 && ids_in_use.size() != 0) begin
      pick = ids_in_use[$urandom_range(ids_in_use.size() - 1)];
      send_request(iba_pkg::CMD_RELEASE, id_t'($urandom), id_t'($urandom), pick);
    end else begin
      send_request(iba_pkg::CMD_RELEASE, id_t'($urandom), id_t'($urandom), id_t'($urandom));
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.expected_grants.size() != 0) begin
      @(posedge clk_i);
    end
    // a release may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // result side: checking, random stalls and one long hold-off
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        sb.check_grant(granted_id_o, granted_o);
      end
      if (hold_off_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: watchdog, no item moved for %0d cycles", $time, QUIET_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: size limits, reserved id, double release, unused fields
    send_request(iba_pkg::CMD_ALLOC, 16'h0000, 16'h0000, 16'h0000);
    send_request(iba_pkg::CMD_ALLOC, SIZE_MAX, SIZE_MAX, 16'hffff);
    send_request(iba_pkg::CMD_ALLOC, iba_pkg::SIZE_LIMIT, 16'h0000, 16'h0000);
    send_request(iba_pkg::CMD_ALLOC, 16'h0000, iba_pkg::SIZE_LIMIT, 16'h0000);
    send_request(iba_pkg::CMD_ALLOC, 16'hffff, 16'hffff, 16'hffff);
    send_request(iba_pkg::CMD_ALLOC, 16'h8000, SIZE_MAX, 16'h5555);
    send_request(iba_pkg::CMD_RELEASE, 16'h0000, 16'h0000, 16'h0000);
    send_request(iba_pkg::CMD_ALLOC, 16'h0001, 16'h0001, 16'h0000);
    send_request(iba_pkg::CMD_RELEASE, 16'hffff, 16'hffff, 16'h0002);
    send_request(iba_pkg::CMD_RELEASE, 16'h0000, 16'h0000, 16'h0002);
    send_request(iba_pkg::CMD_ALLOC, 16'h0011, 16'h0fa0, 16'haaaa);
    send_request(iba_pkg::CMD_RELEASE, 16'h0000, 16'h0000, 16'hffff);
    send_request(iba_pkg::CMD_RELEASE, 16'h0000, 16'h0000, 16'h0020);
    send_request(iba_pkg::CMD_RELEASE, 16'h0000, 16'h0000, 16'h0001);
    send_request(iba_pkg::CMD_ALLOC, 16'h0fff, 16'h0000, 16'h0000);
    for (int i = 0; i < 8; i++) begin
      send_request(iba_pkg::CMD_ALLOC, id_t'(i), id_t'(SIZE_MAX - i), id_t'(i));
    end
    wait_drained();

    // receiver holds off while the sender keeps offering
    idle_pct     = 0;
    hold_off_req <= 1'b1;
    for (int i = 0; i < 20; i++) begin
      random_request();
    end
    idle_pct = IDLE_PCT;

    for (int i = 0; i < 380; i++) begin
      random_request();
    end

    idle_pct = 0;
    for (int i = 0; i < 150; i++) begin
      random_request();
    end
    idle_pct = IDLE_PCT;

    wait_drained();
    for (int i = 0; i < 250; i++) begin
      random_request();
    end

    wait_drained();
    $display("%0d items sent: %0d grants, %0d refusals checked, %0d releases",
             items_sent, sb.grants_checked, sb.refusals_checked, sb.releases_noted);
    $display("highest identifier granted %0d, %0d still held at the end",
             sb.highest_id, ids_in_use.size());
    if (sb.mismatches == 0 && sb.expected_grants.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
